[design/rau_pkg.sv]
// Package for the rational accumulator unit: codes, request and result types.
// No dependencies.
`timescale 1ns / 1ps
package rau_pkg;

  localparam int WordBitsDefault = 32;

  typedef enum logic [2:0] {
    FUNC_LOAD   = 3'd0,
    FUNC_RECIP  = 3'd1,
    FUNC_SIMP   = 3'd2,
    FUNC_MULINT = 3'd3,
    FUNC_MULFR  = 3'd4,
    FUNC_ADD    = 3'd5,
    FUNC_SUB    = 3'd6
  } func_t;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] operand_num;
    logic signed [31:0] operand_den;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_num;
    logic signed [31:0] result_den;
    logic               error_flag;
  } rsp_t;

  // Divider handshake between the sequencer and the shared divider.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

[design/rau_divider.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_divider #(
  parameter int WordBits = rau_pkg::WordBitsDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rau_pkg::div_ctl_t     ctl,
  input  logic [WordBits-1:0]   dividend,
  input  logic [WordBits-1:0]   divisor,
  output rau_pkg::div_sts_t     sts,
  output logic [WordBits-1:0]   quotient,
  output logic [WordBits-1:0]   remainder
);
  localparam int CntBits = $clog2(WordBits + 1);

  logic [CntBits-1:0]  count;
  logic                busy;
  logic                done;
  logic [WordBits-1:0] dvs;
  logic [WordBits:0]   trial;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {remainder, quotient[WordBits-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy  <= 1'b1;
        count <= CntBits'(WordBits);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CntBits'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      if (!trial[WordBits]) begin
        remainder <= trial[WordBits-1:0];
        quotient  <= {quotient[WordBits-2:0], 1'b1};
      end else begin
        remainder <= {remainder[WordBits-2:0], quotient[WordBits-1]};
        quotient  <= {quotient[WordBits-2:0], 1'b0};
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
endmodule

[design/rational_accumulator_unit.sv]
// Top level of the rational accumulator unit: sequencer, multiplier, divider, fraction.
// Depends on rau_pkg and rau_divider.
`timescale 1ns / 1ps
// The unit holds one fraction and applies one request at a time. A request is
// taken only when the unit is idle and no result waits; its result shows the
// held fraction afterward. Load, reciprocal and unused codes finish in S_EXEC;
// integer multiply then runs S_MUL1, fraction multiply S_MUL1 and S_MUL2, add
// and subtract S_MUL1 to S_MUL3, since one shared multiplier makes one product
// per cycle. Simplify runs the Euclidean loop on one shared restoring divider.
// Each remainder step starts from S_GCD and waits in S_GCDW for the divider to
// finish; S_DIVN and S_DIVD then divide the numerator and denominator by the
// common divisor. The loop takes at most about 46 remainder steps for 32-bit
// words. The divider sets the rate of simplify.
module rational_accumulator_unit #(
  parameter int WordBits = rau_pkg::WordBitsDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  rau_pkg::req_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output rau_pkg::rsp_t   out_data
);
  localparam int W = WordBits;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_EXEC  = 9'b000000010,
    S_MUL1  = 9'b000000100,
    S_MUL2  = 9'b000001000,
    S_MUL3  = 9'b000010000,
    S_GCD   = 9'b000100000,
    S_GCDW  = 9'b001000000,
    S_DIVN  = 9'b010000000,
    S_DIVD  = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [2:0]   func;
  logic [W-1:0] opn, opd;
  logic [W-1:0] acc_num, acc_den;
  logic [W-1:0] prod_a;       // first registered product
  logic [W-1:0] prod;         // product register
  logic [W-1:0] hi, lo, mag_n, mag_d;
  logic         nneg, dneg;
  logic         err;
  logic         res_pending;

  // Shared multiplier: the operand pair is chosen by the state.
  logic [W-1:0] mul_a, mul_b;
  always_comb begin
    mul_a = acc_num;
    mul_b = opn;
    case (state)
      S_MUL1: begin
        mul_a = acc_num;
        mul_b = (rau_pkg::func_t'(func) == rau_pkg::FUNC_ADD ||
                 rau_pkg::func_t'(func) == rau_pkg::FUNC_SUB) ? opd : opn;
      end
      S_MUL2: begin
        mul_a = acc_den;
        mul_b = (rau_pkg::func_t'(func) == rau_pkg::FUNC_MULFR) ? opd : opn;
      end
      S_MUL3: begin
        mul_a = acc_den;
        mul_b = opd;
      end
      default: begin
        mul_a = acc_num;
        mul_b = opn;
      end
    endcase
  end

  logic [2*W-1:0] mul_full;
  assign mul_full = mul_a * mul_b;

  // Shared divider.
  rau_pkg::div_ctl_t div_ctl;
  rau_pkg::div_sts_t div_sts;
  logic [W-1:0]      div_a, div_b, div_q, div_r;

  rau_divider #(.WordBits(W)) u_div (
    .clk(clk), .rst(rst), .ctl(div_ctl), .dividend(div_a), .divisor(div_b),
    .sts(div_sts), .quotient(div_q), .remainder(div_r)
  );

  // The divider latches its operands on start. The numerator divide starts
  // from S_GCD once the loop ends, the denominator divide from S_DIVN.
  always_comb begin
    div_a = hi;
    div_b = lo;
    case (state)
      S_GCD: begin
        if (lo == '0) begin
          div_a = mag_n;
          div_b = hi;
        end
      end
      S_DIVN: begin
        div_a = mag_d;
        div_b = hi;
      end
      default: begin
        div_a = hi;
        div_b = lo;
      end
    endcase
  end

  assign in_stall  = (state != S_IDLE) || res_pending;
  assign out_valid = res_pending;

  // Sequencer.
  always_comb begin
    state_next    = state;
    div_ctl.start = 1'b0;
    case (state)
      S_IDLE: if (in_valid && !in_stall) state_next = S_EXEC;
      S_EXEC: begin
        case (rau_pkg::func_t'(func))
          rau_pkg::FUNC_MULINT, rau_pkg::FUNC_MULFR,
          rau_pkg::FUNC_ADD, rau_pkg::FUNC_SUB: state_next = S_MUL1;
          rau_pkg::FUNC_SIMP: state_next = S_GCD;
          default: state_next = S_IDLE;
        endcase
      end
      S_MUL1: begin
        if (rau_pkg::func_t'(func) == rau_pkg::FUNC_MULINT) state_next = S_IDLE;
        else state_next = S_MUL2;
      end
      S_MUL2: begin
        if (rau_pkg::func_t'(func) == rau_pkg::FUNC_MULFR) state_next = S_IDLE;
        else state_next = S_MUL3;
      end
      S_MUL3: state_next = S_IDLE;
      S_GCD: begin
        if (lo == '0) begin
          if (hi == '0) state_next = S_IDLE;
          else begin
            state_next    = S_DIVN;
            div_ctl.start = 1'b1;
          end
        end else begin
          state_next    = S_GCDW;
          div_ctl.start = 1'b1;
        end
      end
      S_GCDW: if (div_sts.done) state_next = S_GCD;
      S_DIVN: begin
        if (div_sts.done) begin
          state_next    = S_DIVD;
          div_ctl.start = 1'b1;
        end
      end
      S_DIVD: if (div_sts.done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      res_pending <= 1'b0;
      acc_num     <= '0;
      acc_den     <= W'(1);
      err         <= 1'b0;
    end else begin
      state <= state_next;
      if (res_pending && !out_stall) res_pending <= 1'b0;
      if (state != S_IDLE && state_next == S_IDLE) res_pending <= 1'b1;
      case (state)
        S_IDLE: if (in_valid && !in_stall) err <= 1'b0;
        S_EXEC: begin
          case (rau_pkg::func_t'(func))
            rau_pkg::FUNC_LOAD: begin
              acc_num <= opn;
              acc_den <= opd;
            end
            rau_pkg::FUNC_RECIP: begin
              acc_num <= acc_den;
              acc_den <= acc_num;
            end
            default: ;
          endcase
        end
        S_MUL1: begin
          if (rau_pkg::func_t'(func) == rau_pkg::FUNC_MULINT)
            acc_num <= mul_full[W-1:0];
        end
        S_MUL2: begin
          if (rau_pkg::func_t'(func) == rau_pkg::FUNC_MULFR) begin
            acc_num <= prod_a;
            acc_den <= mul_full[W-1:0];
          end
        end
        S_MUL3: begin
          if (rau_pkg::func_t'(func) == rau_pkg::FUNC_ADD)
            acc_num <= prod_a + prod;
          else
            acc_num <= prod_a - prod;
          acc_den <= mul_full[W-1:0];
        end
        S_GCD: if (lo == '0 && hi == '0) err <= 1'b1;
        S_DIVN: if (div_sts.done) acc_num <= nneg ? W'(-div_q) : div_q;
        S_DIVD: if (div_sts.done) acc_den <= dneg ? W'(-div_q) : div_q;
        default: ;
      endcase
    end
  end

  // Payload and loop registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && !in_stall) begin
      func <= in_data.func;
      opn  <= W'(in_data.operand_num);
      opd  <= W'(in_data.operand_den);
    end
    case (state)
      S_EXEC: begin
        nneg  <= acc_num[W-1];
        dneg  <= acc_den[W-1];
        mag_n <= acc_num[W-1] ? W'(-acc_num) : acc_num;
        mag_d <= acc_den[W-1] ? W'(-acc_den) : acc_den;
        begin
          logic [W-1:0] a, b;
          a = acc_num[W-1] ? W'(-acc_num) : acc_num;
          b = acc_den[W-1] ? W'(-acc_den) : acc_den;
          hi <= (a > b) ? a : b;
          lo <= (a > b) ? b : a;
        end
      end
      S_MUL1: prod_a <= mul_full[W-1:0];
      S_MUL2: prod   <= mul_full[W-1:0];
      S_GCDW: begin
        if (div_sts.done) begin
          hi <= lo;
          lo <= div_r;
        end
      end
      default: ;
    endcase
  end

  assign out_data.result_num = 32'(signed'(acc_num));
  assign out_data.result_den = 32'(signed'(acc_den));
  assign out_data.error_flag = err;
endmodule

[design/rau_checker.sv]
// Port-level checker for the rational accumulator unit, bound to the top.
// Depends on rau_pkg and rational_accumulator_unit.
`timescale 1ns / 1ps
module rau_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input rau_pkg::rsp_t out_data
);
  // A result waiting blocks new requests.
  a_block: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("request taken while result waits");
  // An accepted request never shows a result in the cycle after it is taken.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !out_valid) else $error("result too early");
  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");
  // The error flag is only raised by simplify with zero parts.
  a_err: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.error_flag) |->
    (out_data.result_num == 0 && out_data.result_den == 0))
    else $error("error flag without 0/0");
endmodule

bind rational_accumulator_unit rau_checker u_rau_checker (.*);

[verif/rational_accumulator_unit_tb.sv]
// Self-checking testbench for rational_accumulator_unit: a directed table, then random requests.
// Each result is checked against a behavioral fraction predictor. Depends on rau_pkg and the RTL.
`timescale 1ns / 1ps
module rational_accumulator_unit_tb;

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_stall;
  rau_pkg::req_t  in_data;
  logic           out_valid;
  logic           out_stall;
  rau_pkg::rsp_t  out_data;

  // The unused function code, outside the package enum.
  localparam logic [2:0] FuncUnused = 3'd7;
  localparam int NumDirected = 22;
  localparam int NumRandom = 1150;

  rational_accumulator_unit dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Predictor state: the fraction as the block should hold it.
  logic [31:0]    frac_num;
  logic [31:0]    frac_den;
  rau_pkg::rsp_t  expected_results[$];
  int             failures;
  bit             sending_done;
  bit             hold_off_active;

  // Greatest-common-divisor reduction; returns 1 on 0/0 and leaves the fraction as is.
  function automatic bit reduce_fraction();
    logic [31:0] mag_n, mag_d, hi, lo, tmp;
    bit neg_n, neg_d;
    neg_n = frac_num[31];
    neg_d = frac_den[31];
    mag_n = neg_n ? -frac_num : frac_num;
    mag_d = neg_d ? -frac_den : frac_den;
    hi = (mag_n > mag_d) ? mag_n : mag_d;
    lo = (mag_n > mag_d) ? mag_d : mag_n;
    while (lo != 0) begin
      tmp = lo;
      lo = hi % lo;
      hi = tmp;
    end
    if (hi == 0) return 1'b1;
    mag_n = mag_n / hi;
    mag_d = mag_d / hi;
    frac_num = neg_n ? -mag_n : mag_n;
    frac_den = neg_d ? -mag_d : mag_d;
    return 1'b0;
  endfunction

  // Applies one request to the predictor and returns the result the block should show.
  function automatic rau_pkg::rsp_t apply_request(rau_pkg::req_t req);
    logic [31:0] on, od, tmp;
    rau_pkg::rsp_t r;
    bit err;
    on = req.operand_num;
    od = req.operand_den;
    err = 1'b0;
    case (req.func)
      rau_pkg::FUNC_LOAD: begin
        frac_num = on;
        frac_den = od;
      end
      rau_pkg::FUNC_RECIP: begin
        tmp = frac_num;
        frac_num = frac_den;
        frac_den = tmp;
      end
      rau_pkg::FUNC_SIMP: err = reduce_fraction();
      rau_pkg::FUNC_MULINT: frac_num = frac_num * on;
      rau_pkg::FUNC_MULFR: begin
        frac_num = frac_num * on;
        frac_den = frac_den * od;
      end
      rau_pkg::FUNC_ADD: begin
        frac_num = frac_num * od + on * frac_den;
        frac_den = frac_den * od;
      end
      rau_pkg::FUNC_SUB: begin
        frac_num = frac_num * od - on * frac_den;
        frac_den = frac_den * od;
      end
      default: ;
    endcase
    r.result_num = frac_num;
    r.result_den = frac_den;
    r.error_flag = err;
    return r;
  endfunction

  // Directed table. A row with has_fixed set carries a result read straight off the behavior.
  typedef struct {
    logic [2:0]     func;
    logic [31:0]    num;
    logic [31:0]    den;
    bit             has_fixed;
    rau_pkg::rsp_t  fixed;
  } directed_row_t;

  directed_row_t directed_rows[NumDirected];

  function automatic directed_row_t row(logic [2:0] f, logic [31:0] n, logic [31:0] d,
                                        bit fx, logic [31:0] rn, logic [31:0] rd, bit re);
    directed_row_t x;
    x.func = f;
    x.num = n;
    x.den = d;
    x.has_fixed = fx;
    x.fixed.result_num = rn;
    x.fixed.result_den = rd;
    x.fixed.error_flag = re;
    return x;
  endfunction

  initial begin
    // The unused code right after reset shows the reset fraction 0/1.
    directed_rows[0]  = row(FuncUnused, 32'h1234, 32'h5678, 1, 0, 1, 0);
    directed_rows[1]  = row(rau_pkg::FUNC_SIMP, 0, 0, 1, 0, 1, 0);
    directed_rows[2]  = row(rau_pkg::FUNC_LOAD, 0, 0, 1, 0, 0, 0);
    // Simplify of 0/0 leaves the fraction and raises the error flag.
    directed_rows[3]  = row(rau_pkg::FUNC_SIMP, 0, 0, 1, 0, 0, 1);
    directed_rows[4]  = row(rau_pkg::FUNC_LOAD, 32'h8000_0000, 32'h7fff_ffff, 1,
                            32'h8000_0000, 32'h7fff_ffff, 0);
    directed_rows[5]  = row(rau_pkg::FUNC_RECIP, 0, 0, 1, 32'h7fff_ffff, 32'h8000_0000, 0);
    directed_rows[6]  = row(rau_pkg::FUNC_SIMP, 0, 0, 0, 0, 0, 0);
    // Most negative value over itself reduces to a wrapped sign.
    directed_rows[7]  = row(rau_pkg::FUNC_LOAD, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0);
    directed_rows[8]  = row(rau_pkg::FUNC_SIMP, 0, 0, 0, 0, 0, 0);
    // Zero numerator: the denominator's magnitude is the divisor.
    directed_rows[9]  = row(rau_pkg::FUNC_LOAD, 0, -32'sd12, 0, 0, 0, 0);
    directed_rows[10] = row(rau_pkg::FUNC_SIMP, 0, 0, 1, 0, 32'hffff_ffff, 0);
    directed_rows[11] = row(rau_pkg::FUNC_LOAD, -32'sd30, 0, 0, 0, 0, 0);
    directed_rows[12] = row(rau_pkg::FUNC_SIMP, 0, 0, 1, 32'hffff_ffff, 0, 0);
    directed_rows[13] = row(rau_pkg::FUNC_LOAD, 6, 8, 0, 0, 0, 0);
    directed_rows[14] = row(rau_pkg::FUNC_MULINT, 32'h7fff_ffff, 0, 0, 0, 0, 0);
    directed_rows[15] = row(rau_pkg::FUNC_MULFR, 32'h8000_0000, 32'hffff_ffff, 0, 0, 0, 0);
    directed_rows[16] = row(rau_pkg::FUNC_LOAD, 1, 3, 0, 0, 0, 0);
    directed_rows[17] = row(rau_pkg::FUNC_ADD, 1, 6, 0, 0, 0, 0);
    directed_rows[18] = row(rau_pkg::FUNC_SIMP, 0, 0, 0, 0, 0, 0);
    directed_rows[19] = row(rau_pkg::FUNC_SUB, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0);
    directed_rows[20] = row(rau_pkg::FUNC_MULFR, 0, 0, 0, 0, 0, 0);
    directed_rows[21] = row(rau_pkg::FUNC_SIMP, 0, 0, 0, 0, 0, 0);
  end

  // Random operand: mostly small values so simplify finds common factors, sometimes full words.
  function automatic logic [31:0] random_operand();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h0} | $urandom_range(0, 3);
      2:       return -$urandom_range(0, 60);
      default: return $urandom_range(0, 60) * (1 << $urandom_range(0, 4));
    endcase
  endfunction

  // Offers one request and waits until the block takes it. Valid stays high
  // afterward; the caller drops it when a gap follows.
  task automatic offer_request(rau_pkg::req_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic sender_gap();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender: directed table, a pause to drain, then random requests.
  initial begin
    rau_pkg::req_t req;
    rau_pkg::rsp_t predicted;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    sending_done = 1'b0;
    failures = 0;
    frac_num = 32'd0;
    frac_den = 32'd1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < NumDirected; i++) begin
      req.func = directed_rows[i].func;
      req.operand_num = directed_rows[i].num;
      req.operand_den = directed_rows[i].den;
      predicted = apply_request(req);
      // Fixed rows double-check the predictor against the value read off by hand.
      if (directed_rows[i].has_fixed && predicted !== directed_rows[i].fixed) begin
        $error("row %0d: fixed result %h, predicted %h", i, directed_rows[i].fixed, predicted);
        failures++;
      end
      expected_results.push_back(predicted);
      offer_request(req);
      sender_gap();
    end
    // Pause until the directed results have all come back.
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    for (int i = 0; i < NumRandom; i++) begin
      req.func = 3'($urandom_range(0, 7));
      // Keep loads frequent so fractions stay in a useful range.
      if ($urandom_range(0, 5) == 0) req.func = rau_pkg::FUNC_LOAD;
      req.operand_num = random_operand();
      req.operand_den = random_operand();
      expected_results.push_back(apply_request(req));
      offer_request(req);
      // Back-to-back stretch while the receiver holds off.
      if (!hold_off_active) sender_gap();
    end
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  // Receiver: random stalls and one long hold-off so the block backs up its input.
  initial begin
    int stall_cycles;
    int accepted;
    out_stall = 1'b1;
    hold_off_active = 1'b0;
    accepted = 0;
    @(negedge rst);
    forever begin
      if (accepted == 200) begin
        hold_off_active <= 1'b1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off_active <= 1'b0;
      end else begin
        stall_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if (stall_cycles != 0) begin
          out_stall <= 1'b1;
          repeat (stall_cycles) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      accepted++;
    end
  end

  // Checker: compares every accepted result with the oldest expectation.
  always @(posedge clk) begin
    rau_pkg::rsp_t exp_rsp;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with no expectation: %h", out_data);
        failures++;
      end else begin
        exp_rsp = expected_results.pop_front();
        if (out_data.result_num !== exp_rsp.result_num) begin
          $error("result_num expected %h actual %h", exp_rsp.result_num, out_data.result_num);
          failures++;
        end
        if (out_data.result_den !== exp_rsp.result_den) begin
          $error("result_den expected %h actual %h", exp_rsp.result_den, out_data.result_den);
          failures++;
        end
        if (out_data.error_flag !== exp_rsp.error_flag) begin
          $error("error_flag expected %b actual %b", exp_rsp.error_flag, out_data.error_flag);
          failures++;
        end
      end
    end
  end

  // End of run: drain, keep watching for stray results, then report.
  initial begin
    wait (sending_done);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (1600) @(posedge clk);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("rational_accumulator_unit regression: pass");
    end else begin
      $display("rational_accumulator_unit regression: fail");
    end
    $finish;
  end

  // Watchdog: worst case is far below this even with every request a long simplify.
  initial begin
    #(12 * 20_000_000);
    $display("rational_accumulator_unit regression: fail");
    $finish;
  end

endmodule
